FILE: sv/byte_ring_buffer_fifo_macros.svh
// Assertion macros for the checker module.
`ifndef BYTE_RING_BUFFER_FIFO_MACROS_SVH
`define BYTE_RING_BUFFER_FIFO_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BRBF_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("brbf assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define BRBF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("brbf assertion failed");

`endif

FILE: sv/brbf_pkg.sv
package brbf_pkg;

   localparam int OP_W   = 3;
   localparam int BYTE_W = 8;
   localparam int CNT_W  = 5;

   localparam int DEPTH_DEFAULT = 16;
   localparam int RESULT_CAP    = 16;

   localparam logic [OP_W-1:0] OP_WRITE = 3'd0;
   localparam logic [OP_W-1:0] OP_READ  = 3'd1;
   localparam logic [OP_W-1:0] OP_PEEK  = 3'd2;
   localparam logic [OP_W-1:0] OP_SKIP  = 3'd3;
   localparam logic [OP_W-1:0] OP_CLEAR = 3'd4;
   localparam logic [OP_W-1:0] OP_SUM   = 3'd5;

endpackage

FILE: sv/brbf_ram.sv
module brbf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/byte_ring_buffer_fifo.sv
// Byte FIFO on a ring of DEPTH entries held in one synchronous RAM.
// Input channel (req_*): one operation per beat: write a byte, read, peek,
// skip, clear, or query the 8-bit wrapping sum of the stored bytes.
// Output channel (rsp_*): one beat for each operation, except that a read or
// peek of n bytes gives n beats, oldest byte first, with rsp_last on the final
// one. Every beat carries the fill level after the operation.
// Write, skip, clear and empty reads finish at the accept edge, where the result is
// registered; back-to-back writes stream at one beat per cycle while rsp_ready is high.
// A read or peek of n bytes occupies the block until its last byte is loaded; bytes
// leave at one per cycle once the first RAM read returns, while the receiver keeps up.
// A checksum query walks every stored byte through the RAM read port.
// Reset empties the buffer and drops any pending result; the RAM contents
// are not cleared and no clearing pass is needed.
// When the receiver stalls, the output register holds its beat, the walk
// keeps at most one byte waiting in the RAM data register, and req_ready
// stays low until the output register can take a new beat.
module byte_ring_buffer_fifo #(
   parameter int DEPTH = brbf_pkg::DEPTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [brbf_pkg::OP_W-1:0]     req_op,
   input  logic [brbf_pkg::BYTE_W-1:0]   req_data_byte,
   input  logic [brbf_pkg::CNT_W-1:0]    req_count,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [brbf_pkg::BYTE_W-1:0]   rsp_out_byte,
   output logic [brbf_pkg::CNT_W-1:0]    rsp_done_count,
   output logic [brbf_pkg::CNT_W-1:0]    rsp_fill_level,
   output logic [brbf_pkg::BYTE_W-1:0]   rsp_checksum,
   output logic                          rsp_last
);

   import brbf_pkg::*;

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int SW = CW + 1;
   localparam int XW = CW + CNT_W;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_WALK = 3'b010,
      ST_FIN  = 3'b100
   } state_type;

   state_type         state_ff, state_in;
   logic [PW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [PW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic [PW-1:0]     walk_ptr_ff, walk_ptr_in;
   logic [CW-1:0]     walk_len_ff, walk_len_in;
   logic [CW-1:0]     issue_cnt_ff, issue_cnt_in;
   logic [CW-1:0]     move_cnt_ff, move_cnt_in;
   logic              sum_mode_ff, sum_mode_in;
   logic              pend_ff, pend_in;
   logic [BYTE_W-1:0] sum_ff, sum_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0] rsp_out_byte_ff, rsp_out_byte_in;
   logic [CNT_W-1:0]  rsp_done_ff, rsp_done_in;
   logic [CNT_W-1:0]  rsp_fill_ff, rsp_fill_in;
   logic [BYTE_W-1:0] rsp_sum_ff, rsp_sum_in;
   logic              rsp_last_ff, rsp_last_in;

   logic              out_free;
   logic              accept;
   logic [XW-1:0]     req_ext;
   logic [XW-1:0]     cnt_ext;
   logic [XW-1:0]     avail;
   logic [XW-1:0]     capped;
   logic [CW-1:0]     n_skip;
   logic [CW-1:0]     n_rd;
   logic              move;
   logic              issue;
   logic              load;
   logic [BYTE_W-1:0] load_byte;
   logic [CW-1:0]     load_done;
   logic [BYTE_W-1:0] load_sum;
   logic              load_last;

   logic              ram_we;
   logic              ram_re;
   logic [PW-1:0]     ram_raddr;
   logic [BYTE_W-1:0] ram_rdata;

   function automatic logic [PW-1:0] ptr_add(logic [PW-1:0] p, logic [CW-1:0] k);
      logic [SW-1:0] s;
      s = SW'(p) + SW'(k);
      if (s >= SW'(DEPTH)) begin
         s = s - SW'(DEPTH);
      end
      return s[PW-1:0];
   endfunction

   function automatic logic [CNT_W-1:0] to_cnt(logic [CW-1:0] v);
      logic [XW-1:0] w;
      w = {{CNT_W{1'b0}}, v};
      return w[CNT_W-1:0];
   endfunction

   brbf_ram #(
      .WIDTH(BYTE_W),
      .DEPTH(DEPTH)
   ) u_ram (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(wr_ptr_ff),
      .wr_data(req_data_byte),
      .rd_en  (ram_re),
      .rd_addr(ram_raddr),
      .rd_data(ram_rdata)
   );

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && out_free;
   assign accept    = req_valid && req_ready;

   assign req_ext = {{CW{1'b0}}, req_count};
   assign cnt_ext = {{CNT_W{1'b0}}, cnt_ff};
   assign avail   = (req_ext > cnt_ext) ? cnt_ext : req_ext;
   assign capped  = (avail > XW'(RESULT_CAP)) ? XW'(RESULT_CAP) : avail;
   assign n_skip  = avail[CW-1:0];
   assign n_rd    = capped[CW-1:0];

   assign move  = (state_ff == ST_WALK) && pend_ff && (sum_mode_ff || out_free);
   assign issue = (state_ff == ST_WALK) && (issue_cnt_ff != walk_len_ff)
                  && (!pend_ff || move);

   always_comb begin
      state_in     = state_ff;
      rd_ptr_in    = rd_ptr_ff;
      wr_ptr_in    = wr_ptr_ff;
      cnt_in       = cnt_ff;
      walk_ptr_in  = walk_ptr_ff;
      walk_len_in  = walk_len_ff;
      issue_cnt_in = issue_cnt_ff;
      move_cnt_in  = move_cnt_ff;
      sum_mode_in  = sum_mode_ff;
      sum_in       = sum_ff;
      pend_in      = issue || (pend_ff && !move);
      ram_we       = 1'b0;
      ram_re       = issue;
      ram_raddr    = walk_ptr_ff;
      load         = 1'b0;
      load_byte    = '0;
      load_done    = '0;
      load_sum     = '0;
      load_last    = 1'b1;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_op)
                  OP_WRITE: begin
                     load = 1'b1;
                     if (cnt_ff != CW'(DEPTH)) begin
                        ram_we    = 1'b1;
                        wr_ptr_in = ptr_add(wr_ptr_ff, CW'(1));
                        cnt_in    = cnt_ff + CW'(1);
                        load_done = CW'(1);
                     end
                  end
                  OP_READ, OP_PEEK: begin
                     if (n_rd == '0) begin
                        load = 1'b1;
                     end else begin
                        state_in     = ST_WALK;
                        walk_ptr_in  = rd_ptr_ff;
                        walk_len_in  = n_rd;
                        issue_cnt_in = '0;
                        move_cnt_in  = '0;
                        sum_mode_in  = 1'b0;
                        if (req_op == OP_READ) begin
                           rd_ptr_in = ptr_add(rd_ptr_ff, n_rd);
                           cnt_in    = cnt_ff - n_rd;
                        end
                     end
                  end
                  OP_SKIP: begin
                     load      = 1'b1;
                     rd_ptr_in = ptr_add(rd_ptr_ff, n_skip);
                     cnt_in    = cnt_ff - n_skip;
                     load_done = n_skip;
                  end
                  OP_CLEAR: begin
                     load      = 1'b1;
                     rd_ptr_in = '0;
                     wr_ptr_in = '0;
                     cnt_in    = '0;
                  end
                  OP_SUM: begin
                     if (cnt_ff == '0) begin
                        load = 1'b1;
                     end else begin
                        state_in     = ST_WALK;
                        walk_ptr_in  = rd_ptr_ff;
                        walk_len_in  = cnt_ff;
                        issue_cnt_in = '0;
                        move_cnt_in  = '0;
                        sum_mode_in  = 1'b1;
                        sum_in       = '0;
                     end
                  end
                  default: begin
                     load = 1'b1;
                  end
               endcase
            end
         end
         ST_WALK: begin
            if (issue) begin
               walk_ptr_in  = ptr_add(walk_ptr_ff, CW'(1));
               issue_cnt_in = issue_cnt_ff + CW'(1);
            end
            if (move) begin
               move_cnt_in = move_cnt_ff + CW'(1);
               if (sum_mode_ff) begin
                  sum_in = sum_ff + ram_rdata;
                  if (move_cnt_ff + CW'(1) == walk_len_ff) begin
                     state_in = ST_FIN;
                  end
               end else begin
                  load      = 1'b1;
                  load_byte = ram_rdata;
                  load_done = walk_len_ff;
                  load_last = (move_cnt_ff + CW'(1) == walk_len_ff);
                  if (load_last) begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end
         ST_FIN: begin
            if (out_free) begin
               load     = 1'b1;
               load_sum = sum_ff;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in    = load || (rsp_valid_ff && !rsp_ready);
      rsp_out_byte_in = load ? load_byte : rsp_out_byte_ff;
      rsp_done_in     = load ? to_cnt(load_done) : rsp_done_ff;
      rsp_fill_in     = load ? to_cnt(cnt_in) : rsp_fill_ff;
      rsp_sum_in      = load ? load_sum : rsp_sum_ff;
      rsp_last_in     = load ? load_last : rsp_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_ptr_ff    <= '0;
         wr_ptr_ff    <= '0;
         cnt_ff       <= '0;
         issue_cnt_ff <= '0;
         move_cnt_ff  <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_ptr_ff    <= rd_ptr_in;
         wr_ptr_ff    <= wr_ptr_in;
         cnt_ff       <= cnt_in;
         issue_cnt_ff <= issue_cnt_in;
         move_cnt_ff  <= move_cnt_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      walk_ptr_ff     <= walk_ptr_in;
      walk_len_ff     <= walk_len_in;
      sum_mode_ff     <= sum_mode_in;
      sum_ff          <= sum_in;
      rsp_out_byte_ff <= rsp_out_byte_in;
      rsp_done_ff     <= rsp_done_in;
      rsp_fill_ff     <= rsp_fill_in;
      rsp_sum_ff      <= rsp_sum_in;
      rsp_last_ff     <= rsp_last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_byte   = rsp_out_byte_ff;
   assign rsp_done_count = rsp_done_ff;
   assign rsp_fill_level = rsp_fill_ff;
   assign rsp_checksum   = rsp_sum_ff;
   assign rsp_last       = rsp_last_ff;

endmodule

FILE: sv/brbf_check.sv
`include "byte_ring_buffer_fifo_macros.svh"

module brbf_check (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [brbf_pkg::BYTE_W-1:0]   rsp_out_byte,
   input logic [brbf_pkg::CNT_W-1:0]    rsp_done_count,
   input logic [brbf_pkg::BYTE_W-1:0]   rsp_checksum,
   input logic                          rsp_last
);

   // A stalled beat must be held with its payload.
   `BRBF_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_out_byte) && $stable(rsp_last))

   // A data byte and a checksum never come in the same beat.
   `BRBF_ASSERT_SAME(a_byte_or_sum, clock, reset, rsp_valid, rsp_out_byte == 8'd0 || rsp_checksum == 8'd0)

   // A nonzero data byte only comes from a read or peek that moved bytes.
   `BRBF_ASSERT_SAME(a_byte_counted, clock, reset, rsp_valid && rsp_out_byte != 8'd0, rsp_done_count != 5'd0)

   // Only a multi-byte read or peek gives beats without the last flag.
   `BRBF_ASSERT_SAME(a_not_last_walk, clock, reset, rsp_valid && !rsp_last, rsp_done_count != 5'd0 && rsp_checksum == 8'd0)

endmodule

bind byte_ring_buffer_fifo brbf_check u_brbf_check (.*);
